### hw/rtl/rwc_pkg.sv
// Shared types, constants and the cosine ROM contents for the wall column unit.
// No dependencies; every other file uses this package.
package rwc_pkg;

  localparam int COS_TABLE_DEPTH = 1024;

  localparam int ANGLE_W = 15;
  localparam int HEADING_W = 9;
  localparam int WIN_W = 13;
  localparam int COORD_W = 32;
  localparam int DIST_W = 32;
  localparam int HEIGHT_W = 16;
  localparam int FACE_W = 3;
  localparam int QUO_W = 16;
  localparam int CFG_DATA_W = 13;

  localparam int QUARTER_UNITS = 5760;
  localparam int HALF_UNITS = 11520;
  localparam int THREE_Q_UNITS = 17280;
  localparam int FULL_UNITS = 23040;

  // Face codes
  localparam logic [FACE_W-1:0] FACE_0 = 3'd0;
  localparam logic [FACE_W-1:0] FACE_1 = 3'd1;
  localparam logic [FACE_W-1:0] FACE_2 = 3'd2;
  localparam logic [FACE_W-1:0] FACE_3 = 3'd3;
  localparam logic [FACE_W-1:0] FACE_NONE = 3'd4;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_PLAYER_HEADING = 1'b0,
    CFG_WINDOW_HEIGHT  = 1'b1
  } cfg_index_t;

  localparam logic [WIN_W-1:0] WINDOW_HEIGHT_RESET = 13'd720;

  // Quarter-wave angle, table index arithmetic
  localparam int QANG_W = 13;
  localparam int COS_IDX_W = $clog2(COS_TABLE_DEPTH + 1);
  localparam int IDXN_W = $clog2(QUARTER_UNITS * COS_TABLE_DEPTH + QUARTER_UNITS / 2 + 1);
  localparam int RECIP_SH = IDXN_W + 13;
  localparam longint RECIP_VAL = ((64'sd1 <<< RECIP_SH) + QUARTER_UNITS - 1) / QUARTER_UNITS;
  localparam int RECIP_W = RECIP_SH - 11;
  localparam int PROD_W = IDXN_W + RECIP_W;
  localparam int COS_W = 16;

  typedef logic [COS_W-1:0] cos_rom_t [0:COS_TABLE_DEPTH];

  localparam longint Q30 = 64'sd1 <<< 30;

  function automatic cos_rom_t build_cos();
    cos_rom_t tab;
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint v;
    for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
      x = (64'sd1686629713 * longint'(i)) / COS_TABLE_DEPTH;
      x2 = (x * x) >>> 30;
      term = Q30;
      sum = term;
      term = -(term * x2) / Q30; term = term / 2;   sum = sum + term;
      term = -(term * x2) / Q30; term = term / 12;  sum = sum + term;
      term = -(term * x2) / Q30; term = term / 30;  sum = sum + term;
      term = -(term * x2) / Q30; term = term / 56;  sum = sum + term;
      term = -(term * x2) / Q30; term = term / 90;  sum = sum + term;
      term = -(term * x2) / Q30; term = term / 132; sum = sum + term;
      term = -(term * x2) / Q30; term = term / 182; sum = sum + term;
      term = -(term * x2) / Q30; term = term / 240; sum = sum + term;
      if (sum < 0) sum = 0;
      v = (sum + 64'sd16384) >>> 15;
      if (v > 32768) v = 32768;
      tab[i] = v[COS_W-1:0];
    end
    return tab;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos();

  // Payload handed from cell to cell along the divider chain
  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic              last;
    logic              zero;
    logic              sat;
    logic [DIST_W-1:0] cdist;
    logic [DIST_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
  } div_cell_t;

endpackage

### hw/rtl/rwc_ifs.sv
// Channel interfaces: ray input, column result and configuration write.
// Depends on rwc_pkg for field widths.
interface ray_if;
  logic                          valid;
  logic                          ready;
  logic [rwc_pkg::ANGLE_W-1:0]   ray_angle;
  logic [rwc_pkg::COORD_W-1:0]   hit_x;
  logic [rwc_pkg::COORD_W-1:0]   hit_y;
  logic [rwc_pkg::DIST_W-1:0]    raw_distance;
  logic                          last_column;
  modport source (output valid, ray_angle, hit_x, hit_y, raw_distance, last_column,
                  input ready);
  modport sink (input valid, ray_angle, hit_x, hit_y, raw_distance, last_column,
                output ready);
endinterface

interface column_if;
  logic                          valid;
  logic                          ready;
  logic [rwc_pkg::FACE_W-1:0]    wall_face;
  logic [rwc_pkg::DIST_W-1:0]    corrected_distance;
  logic [rwc_pkg::HEIGHT_W-1:0]  slice_height;
  logic signed [15:0]            top_row;
  logic [15:0]                   bottom_row;
  logic                          zero_distance;
  logic                          frame_end;
  modport source (output valid, wall_face, corrected_distance, slice_height, top_row,
                  bottom_row, zero_distance, frame_end, input ready);
  modport sink (input valid, wall_face, corrected_distance, slice_height, top_row,
                bottom_row, zero_distance, frame_end, output ready);
endinterface

interface cfg_if;
  logic                            valid;
  logic                            ready;
  rwc_pkg::cfg_index_t             index;
  logic [rwc_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/rwc_front.sv
// Front pipeline: face tests, angle wrap, cosine index, ROM read, distance
// correction and divider setup. Depends on rwc_pkg and rwc_ifs.
module rwc_front (
  input  logic                         clk,
  input  logic                         rst,
  ray_if.sink                          ray,
  input  logic [rwc_pkg::HEADING_W-1:0] heading,
  input  logic [rwc_pkg::WIN_W-1:0]    win_height,
  output rwc_pkg::div_cell_t           out_data,
  output logic                         out_valid,
  input  logic                         out_ready
);
  import rwc_pkg::*;

  logic v1, v2, v3, v4, v5, v6;
  logic r1, r2, r3, r4, r5, r6;

  // stage 1
  logic [FACE_W-1:0] face1, face2, face3, face4, face5;
  logic              last1, last2, last3, last4, last5;
  logic [DIST_W-1:0] raw1, raw2, raw3, raw4, raw5;
  logic              qgt1, qgt2, qgt3, qgt4;
  logic [QANG_W-1:0] rq1;
  // stage 2..4
  logic [IDXN_W-1:0] idxn2;
  logic [PROD_W-1:0] prod3;
  logic [COS_W-1:0]  cos4;
  // stage 5
  logic [DIST_W-1:0] dist5;

  logic [FACE_W-1:0] face_c;
  logic              yw, xw;
  logic signed [16:0] d_raw, d_wrap;
  logic [13:0]       q_c;
  logic [QANG_W-1:0] r_c;
  logic [47:0]       mul_c;

  assign r6 = !v6 || out_ready;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign ray.ready = r1;
  assign out_valid = v6;

  always_comb begin
    yw = (ray.hit_y[15:0] == 16'd0);
    xw = (ray.hit_x[15:0] == 16'd0);
    face_c = FACE_NONE;
    if ((ray.ray_angle <= ANGLE_W'(QUARTER_UNITS) ||
         ray.ray_angle >= ANGLE_W'(THREE_Q_UNITS)) && yw) face_c = FACE_0;
    if (ray.ray_angle <= ANGLE_W'(HALF_UNITS) && xw) face_c = FACE_1;
    if (ray.ray_angle <= ANGLE_W'(THREE_Q_UNITS) &&
        ray.ray_angle >= ANGLE_W'(QUARTER_UNITS) && yw) face_c = FACE_2;
    else if (ray.ray_angle < ANGLE_W'(FULL_UNITS) &&
             ray.ray_angle > ANGLE_W'(HALF_UNITS) && xw) face_c = FACE_3;
  end

  always_comb begin
    d_raw = $signed({2'b00, ray.ray_angle}) - $signed({2'b00, heading, 6'b000000});
    d_wrap = d_raw;
    if (d_raw < -17'sd11520) d_wrap = d_raw + 17'sd23040;
    else if (d_raw > 17'sd11520) d_wrap = d_raw - 17'sd23040;
    q_c = d_wrap[16] ? 14'(-d_wrap) : 14'(d_wrap);
    r_c = (q_c <= 14'(QUARTER_UNITS)) ? q_c[QANG_W-1:0]
                                      : QANG_W'(14'(HALF_UNITS) - q_c);
  end

  assign mul_c = {16'd0, raw4} * {32'd0, cos4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else begin
      if (r1) v1 <= ray.valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && ray.valid) begin
      face1 <= face_c;
      last1 <= ray.last_column;
      raw1 <= ray.raw_distance;
      qgt1 <= (q_c > 14'(QUARTER_UNITS));
      rq1 <= r_c;
    end
    if (r2 && v1) begin
      face2 <= face1; last2 <= last1; raw2 <= raw1; qgt2 <= qgt1;
      idxn2 <= IDXN_W'(rq1) * IDXN_W'(COS_TABLE_DEPTH) + IDXN_W'(QUARTER_UNITS / 2);
    end
    if (r3 && v2) begin
      face3 <= face2; last3 <= last2; raw3 <= raw2; qgt3 <= qgt2;
      prod3 <= PROD_W'(idxn2) * PROD_W'(RECIP_W'(RECIP_VAL));
    end
    // registered ROM read
    if (r4 && v3) begin
      face4 <= face3; last4 <= last3; raw4 <= raw3; qgt4 <= qgt3;
      cos4 <= COS_ROM[prod3[RECIP_SH +: COS_IDX_W]];
    end
    if (r5 && v4) begin
      face5 <= face4; last5 <= last4; raw5 <= raw4;
      dist5 <= (qgt4 || cos4 == '0) ? '0 : mul_c[46:15];
    end
    if (r6 && v5) begin
      out_data.face <= face5;
      out_data.last <= last5;
      out_data.zero <= (dist5 == '0);
      out_data.sat <= (DIST_W'(win_height) >= dist5);
      out_data.cdist <= dist5;
      out_data.rem <= DIST_W'(win_height);
      out_data.quo <= '0;
    end
  end

endmodule

### hw/rtl/rwc_div_cell.sv
// One cell of the height divider chain: a single restoring quotient bit.
// Depends on rwc_pkg.
module rwc_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  rwc_pkg::div_cell_t in_data,
  input  logic               in_valid,
  output logic               in_ready,
  output rwc_pkg::div_cell_t out_data,
  output logic               out_valid,
  input  logic               out_ready
);
  import rwc_pkg::*;

  logic [DIST_W:0]   trial;
  logic              take;
  div_cell_t         step;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    trial = {in_data.rem, 1'b0};
    take = (trial >= {1'b0, in_data.cdist});
    step = in_data;
    step.rem = take ? DIST_W'(trial - {1'b0, in_data.cdist}) : trial[DIST_W-1:0];
    step.quo = {in_data.quo[QUO_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) out_data <= step;
  end

endmodule

### hw/rtl/raycast_wall_column_unit.sv
// Top level of the wall column unit: configuration registers, front pipeline,
// divider cell chain and output register. Depends on rwc_pkg, rwc_ifs, rwc_front, rwc_div_cell.
//
// Takes one ray per clock while the sink keeps up and returns one column result per ray
// in order, through six front stages (face/angle wrap, index scale, reciprocal
// multiply, cosine ROM read, distance multiply, divider setup), sixteen divider
// cells that each resolve one bit of the slice height, and the output register.
// Every stage holds a valid bit and moves into an empty slot even while the output
// waits, so a stalled sink only blocks input once all stages are full. Write
// player_heading and window_height only while no ray is in flight.
module raycast_wall_column_unit (
  input  logic  clk,
  input  logic  rst,
  ray_if.sink   ray,
  column_if.source column,
  cfg_if.sink   cfg
);
  import rwc_pkg::*;

  logic [HEADING_W-1:0] player_heading;
  logic [WIN_W-1:0]     window_height;

  div_cell_t chain_data [0:QUO_W];
  logic      chain_valid [0:QUO_W];
  logic      chain_ready [0:QUO_W];

  logic [HEIGHT_W-1:0] height_c;
  logic [WIN_W-2:0]    half_c;
  logic                out_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_heading <= '0;
      window_height <= WINDOW_HEIGHT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PLAYER_HEADING: player_heading <= cfg.data[HEADING_W-1:0];
        CFG_WINDOW_HEIGHT:  window_height <= cfg.data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  rwc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .ray        (ray),
    .heading    (player_heading),
    .win_height (window_height),
    .out_data   (chain_data[0]),
    .out_valid  (chain_valid[0]),
    .out_ready  (chain_ready[0])
  );

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    rwc_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_data   (chain_data[g]),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .out_data  (chain_data[g+1]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1])
    );
  end

  assign out_ready = !column.valid || column.ready;
  assign chain_ready[QUO_W] = out_ready;

  always_comb begin
    height_c = chain_data[QUO_W].sat ? '1 : chain_data[QUO_W].quo;
    half_c = window_height[WIN_W-1:1];
  end

  always_ff @(posedge clk) begin
    if (rst) column.valid <= 1'b0;
    else if (out_ready) column.valid <= chain_valid[QUO_W];
  end

  always_ff @(posedge clk) begin
    if (out_ready && chain_valid[QUO_W]) begin
      column.wall_face <= chain_data[QUO_W].face;
      column.corrected_distance <= chain_data[QUO_W].cdist;
      column.slice_height <= height_c;
      column.top_row <= $signed(16'(half_c)) - $signed({1'b0, height_c[15:1]});
      column.bottom_row <= 16'(half_c) + {1'b0, height_c[15:1]};
      column.zero_distance <= chain_data[QUO_W].zero;
      column.frame_end <= chain_data[QUO_W].last;
    end
  end

endmodule

### hw/rtl/rwc_checker.sv
// Port-level checks on the column result channel, bound to the top level.
// Depends on rwc_pkg and raycast_wall_column_unit.
module rwc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         col_valid,
  input logic                         col_ready,
  input logic [rwc_pkg::DIST_W-1:0]   col_dist,
  input logic [rwc_pkg::HEIGHT_W-1:0] col_height,
  input logic [15:0]                  col_top,
  input logic [15:0]                  col_bottom,
  input logic                         col_zero
);
  import rwc_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    col_valid && !col_ready |=> col_valid && $stable(col_dist) && $stable(col_height))
    else $error("column result changed while stalled");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    col_valid |-> (col_zero == (col_dist == '0)))
    else $error("zero_distance disagrees with corrected_distance");

  a_zero_sat: assert property (@(posedge clk) disable iff (rst)
    col_valid && col_zero |-> col_height == '1)
    else $error("zero distance without saturated height");

  a_span: assert property (@(posedge clk) disable iff (rst)
    col_valid |-> 16'(col_bottom - col_top) == {col_height[15:1], 1'b0})
    else $error("top and bottom rows do not span the slice");

  a_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !col_valid)
    else $error("result valid right after reset");

endmodule

bind raycast_wall_column_unit rwc_checker u_rwc_checker (
  .clk        (clk),
  .rst        (rst),
  .col_valid  (column.valid),
  .col_ready  (column.ready),
  .col_dist   (column.corrected_distance),
  .col_height (column.slice_height),
  .col_top    (column.top_row),
  .col_bottom (column.bottom_row),
  .col_zero   (column.zero_distance)
);

### verif/testbench.sv
// Testbench for raycast_wall_column_unit: directed table, then random rays under
// several heading and window settings, checked against an in-bench projection predictor.
// Depends on rwc_pkg and the channel interfaces in rwc_ifs.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rwc_pkg::*;

  typedef struct {
    logic [FACE_W-1:0]   face;
    logic [DIST_W-1:0]   cdist;
    logic [HEIGHT_W-1:0] height;
    logic signed [15:0]  top;
    logic [15:0]         bottom;
    logic                zero;
    logic                last;
  } column_t;

  typedef struct {
    logic [ANGLE_W-1:0] angle;
    logic [31:0]        hx;
    logic [31:0]        hy;
    logic [31:0]        raw;
    logic               last;
    bit                 known;
    logic [FACE_W-1:0]  face;
    logic [DIST_W-1:0]  cdist;
    logic [15:0]        height;
    logic               zero;
  } ray_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ray_if    ray_ch();
  column_if col_ch();
  cfg_if    cfg_ch();

  raycast_wall_column_unit DUT (
    .clk(clk), .rst(rst), .ray(ray_ch), .column(col_ch), .cfg(cfg_ch)
  );

  always #6 clk = ~clk;

  logic [15:0] cos_q15 [0:COS_TABLE_DEPTH];
  logic [8:0]  heading_reg = 9'd0;
  logic [12:0] window_reg = 13'd720;
  column_t     pending_columns [$];
  int          mismatches = 0;
  bit          burst = 1'b0;

  task automatic fill_cosine();
    longint x, x2, term, sum, v;
    for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
      x = (64'sd1686629713 * longint'(i)) / COS_TABLE_DEPTH;
      x2 = (x * x) >>> 30;
      term = 64'sd1 <<< 30;
      sum = term;
      for (int k = 1; k <= 8; k++) begin
        term = -(term * x2) / (64'sd1 <<< 30);
        term = term / ((2 * k - 1) * (2 * k));
        sum = sum + term;
      end
      if (sum < 0) sum = 0;
      v = (sum + 64'sd16384) >>> 15;
      if (v > 32768) v = 32768;
      cos_q15[i] = v[15:0];
    end
  endtask

  function automatic column_t project_column(ray_row_t r);
    column_t res;
    int a, d, q, qa, idx;
    longint c, dist_q, h;
    int half, top, bottom;
    bit xw, yw;
    a = int'(r.angle);
    xw = (r.hx[15:0] == 16'd0);
    yw = (r.hy[15:0] == 16'd0);
    res.face = FACE_NONE;
    if ((a <= QUARTER_UNITS || a >= THREE_Q_UNITS) && yw) res.face = FACE_0;
    if (a <= HALF_UNITS && xw) res.face = FACE_1;
    if (a <= THREE_Q_UNITS && a >= QUARTER_UNITS && yw) res.face = FACE_2;
    else if (a < FULL_UNITS && a > HALF_UNITS && xw) res.face = FACE_3;
    d = a - int'(heading_reg) * 64;
    while (d < -HALF_UNITS) d += FULL_UNITS;
    while (d > HALF_UNITS) d -= FULL_UNITS;
    q = (d < 0) ? -d : d;
    qa = (q <= QUARTER_UNITS) ? q : HALF_UNITS - q;
    idx = (qa * COS_TABLE_DEPTH + QUARTER_UNITS / 2) / QUARTER_UNITS;
    if (idx > COS_TABLE_DEPTH) idx = COS_TABLE_DEPTH;
    c = longint'(cos_q15[idx]);
    if (q > QUARTER_UNITS) c = -c;
    if (c <= 0) dist_q = 0;
    else dist_q = (longint'(r.raw) * c) >>> 15;
    if (dist_q > 64'hFFFF_FFFF) dist_q = 64'hFFFF_FFFF;
    if (dist_q == 0) begin
      res.zero = 1'b1;
      h = 65535;
    end else begin
      res.zero = 1'b0;
      h = (longint'(window_reg) <<< 16) / dist_q;
      if (h > 65535) h = 65535;
    end
    half = int'(window_reg) >> 1;
    top = half - int'(h >> 1);
    bottom = half + int'(h >> 1);
    if (bottom > 65535) bottom = 65535;
    res.cdist = dist_q[31:0];
    res.height = h[15:0];
    res.top = top[15:0];
    res.bottom = bottom[15:0];
    res.last = r.last;
    return res;
  endfunction

  // Hold valid through back-to-back transfers; drop it only before an idle gap
  task automatic send_ray(ray_row_t r);
    column_t want;
    int gap;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      ray_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    ray_ch.valid <= 1'b1;
    ray_ch.ray_angle <= r.angle;
    ray_ch.hit_x <= r.hx;
    ray_ch.hit_y <= r.hy;
    ray_ch.raw_distance <= r.raw;
    ray_ch.last_column <= r.last;
    do @(posedge clk); while (!ray_ch.ready);
    want = project_column(r);
    if (r.known) begin
      want.face = r.face;
      want.cdist = r.cdist;
      want.height = r.height;
      want.zero = r.zero;
    end
    pending_columns.push_back(want);
    @(negedge clk);
  endtask

  // Write only with the pipeline drained; hold off past the full latency
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
    ray_ch.valid <= 1'b0;
    wait (pending_columns.size() == 0);
    repeat (30) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_PLAYER_HEADING) heading_reg = value[8:0];
    else window_reg = value[12:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic ray_row_t random_ray();
    ray_row_t r;
    logic [31:0] raw;
    case ($urandom_range(0, 5))
      0: r.angle = ANGLE_W'($urandom_range(0, 32767));
      1: r.angle = ANGLE_W'(QUARTER_UNITS * $urandom_range(0, 4) + $urandom_range(0, 2) - 1);
      default: r.angle = ANGLE_W'($urandom_range(0, FULL_UNITS - 1));
    endcase
    r.hx = $urandom();
    r.hy = $urandom();
    if ($urandom_range(0, 1)) r.hx[15:0] = 16'd0;
    if ($urandom_range(0, 1)) r.hy[15:0] = 16'd0;
    raw = $urandom();
    case ($urandom_range(0, 4))
      0: r.raw = raw;
      1: r.raw = raw >> $urandom_range(16, 31);
      2: r.raw = (raw == 0) ? 32'd0 : raw >> $urandom_range(0, 31);
      3: r.raw = {12'd0, raw[19:0]};
      default: r.raw = (raw[3:0] == 0) ? 32'd0 : raw >> 8;
    endcase
    r.last = ($urandom_range(0, 15) == 0);
    r.known = 1'b0;
    return r;
  endfunction

  // Directed rows: zero distance rows carry their expected values
  ray_row_t directed [] = '{
    '{15'd0, 32'h0001_0000, 32'h0002_0000, 32'd0, 1'b0, 1'b1, FACE_1, 32'd0, 16'hFFFF, 1'b1},
    '{15'd0, 32'h0000_0001, 32'h0003_0000, 32'd0, 1'b1, 1'b1, FACE_0, 32'd0, 16'hFFFF, 1'b1},
    '{15'd11520, 32'h0001_8000, 32'h0001_8000, 32'd0, 1'b0, 1'b1,
      FACE_NONE, 32'd0, 16'hFFFF, 1'b1},
    '{15'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0, 0, 0, 0, 0},
    '{15'd5760, 32'h0001_0000, 32'h0001_0000, 32'h0004_0000, 1'b0, 1'b0, 0, 0, 0, 0},
    '{15'd5759, 32'h0000_0007, 32'h0001_0000, 32'h0004_0000, 1'b0, 1'b0, 0, 0, 0, 0},
    '{15'd11521, 32'h0001_0000, 32'h0000_0001, 32'h0010_0000, 1'b0, 1'b0, 0, 0, 0, 0},
    '{15'd17280, 32'h0005_0000, 32'h0006_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 0, 0, 0, 0},
    '{15'd17281, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 0, 0, 0, 0},
    '{15'd23039, 32'hFFFF_0000, 32'h0000_1234, 32'h0002_8000, 1'b1, 1'b0, 0, 0, 0, 0},
    '{15'd23040, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 1'b0, 1'b0, 0, 0, 0, 0},
    '{15'd32767, 32'h0002_0000, 32'hFFFF_FFFF, 32'h0003_0000, 1'b0, 1'b0, 0, 0, 0, 0},
    '{15'd2880, 32'h0000_0000, 32'h0000_0000, 32'h0000_0100, 1'b0, 1'b0, 0, 0, 0, 0},
    '{15'd8640, 32'h1234_5678, 32'h8765_4321, 32'h0001_0000, 1'b0, 1'b0, 0, 0, 0, 0},
    '{15'd20160, 32'hAAAA_0000, 32'h5555_5555, 32'h7FFF_FFFF, 1'b1, 1'b0, 0, 0, 0, 0}
  };

  // Sink side: random stall before each result, none while bursting
  initial begin
    int stall;
    col_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        col_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      col_ch.ready <= 1'b1;
      do @(posedge clk); while (!(col_ch.valid && !rst));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    column_t want;
    if (!rst && col_ch.valid && col_ch.ready) begin
      if (pending_columns.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected column result at %0t", $realtime);
      end else begin
        want = pending_columns.pop_front();
        if (col_ch.wall_face !== want.face || col_ch.corrected_distance !== want.cdist ||
            col_ch.slice_height !== want.height || col_ch.top_row !== want.top ||
            col_ch.bottom_row !== want.bottom || col_ch.zero_distance !== want.zero ||
            col_ch.frame_end !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("column mismatch at %0t: exp face %0d dist %h h %0d top %0d bot %0d",
                     $realtime, want.face, want.cdist, want.height, want.top, want.bottom,
                     " z %b l %b, got face %0d dist %h h %0d top %0d bot %0d z %b l %b",
                     want.zero, want.last, col_ch.wall_face, col_ch.corrected_distance,
                     col_ch.slice_height, col_ch.top_row, col_ch.bottom_row,
                     col_ch.zero_distance, col_ch.frame_end);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("** raycast_wall_column_unit: FAILED **");
    $finish;
  end

  initial begin
    logic [8:0]  headings [6];
    logic [12:0] windows  [6];
    headings = '{9'd0, 9'd359, 9'd511, 9'd90, 9'd0, 9'd200};
    windows = '{13'd720, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd480};
    ray_ch.valid = 1'b0;
    ray_ch.ray_angle = '0;
    ray_ch.hit_x = '0;
    ray_ch.hit_y = '0;
    ray_ch.raw_distance = '0;
    ray_ch.last_column = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_PLAYER_HEADING;
    cfg_ch.data = '0;
    fill_cosine();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_ray(directed[i]);
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_PLAYER_HEADING, {4'd0, headings[p]});
      write_reg(CFG_WINDOW_HEIGHT, windows[p]);
      if (p == 1) foreach (directed[i]) if (!directed[i].known) send_ray(directed[i]);
      for (int n = 0; n < 300; n++) begin
        if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        send_ray(random_ray());
      end
      burst = 1'b0;
    end
    ray_ch.valid <= 1'b0;
    wait (pending_columns.size() == 0);
    repeat (30) @(posedge clk);
    if (mismatches == 0) $display("** raycast_wall_column_unit: PASSED **");
    else $display("** raycast_wall_column_unit: FAILED **");
    $finish;
  end
endmodule
